/* src/vpma_pkg.sv */
// Shared types and constants for the variable-period moving average.
`default_nettype none
package vpma_pkg;

	// register index of the sample period (byte address 0)
	localparam logic REG_SAMPLE_PERIOD = 1'b0;

	// sequencer states, one-hot
	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_DIVQ = 12'b0000_0000_0010,
		ST_RD1  = 12'b0000_0000_0100,
		ST_RD2  = 12'b0000_0000_1000,
		ST_UPD  = 12'b0000_0001_0000,
		ST_SETS = 12'b0000_0010_0000,
		ST_DIVS = 12'b0000_0100_0000,
		ST_SETL = 12'b0000_1000_0000,
		ST_DIVL = 12'b0001_0000_0000,
		ST_MUL1 = 12'b0010_0000_0000,
		ST_MUL2 = 12'b0100_0000_0000,
		ST_FIN  = 12'b1000_0000_0000
	} vpma_state_t;

endpackage
`default_nettype wire

/* src/vpma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vpma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* src/variable_period_moving_average.sv */
// Top level of the variable-period moving average filter.
//
//  channel   direction  handshake                    payload
//  input     in         sample_valid / sample_stall  sample, period
//  result    out        average_valid / average_stall average
//  config    in/out     APB psel/penable/pready      paddr, pwdata, prdata
//
// One item is taken at a time: sample_stall stays high from acceptance until the
// result is loaded into the output register.
// One shared restoring divider, one quotient bit a cycle, runs the window
// quotient, the short average and the long average in turn; the short divide
// is skipped while the window holds one sample.
// A period of zero or less gives a zero result without running the divider.
// Reset clears all control state and sums; history entries are only read
// once written, so the history RAM needs no clearing pass.
// A finished result waits in the output register while average_stall is high.
`default_nettype none
module variable_period_moving_average #(
	parameter int HISTORY_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire logic signed [31:0] sample,
	input  wire logic signed [31:0] period,
	output logic                    average_valid,
	input  wire logic               average_stall,
	output logic signed [31:0]      average,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import vpma_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = AW + 34;
	localparam int DW = (SW > 48) ? SW : 48;
	localparam int NW = $clog2(DW);
	localparam logic [DW-1:0] MAX_Q = DW'(HISTORY_DEPTH - 1) << 16;

	vpma_state_t state_q;

	logic [31:0]           sample_period_q;
	logic signed [31:0]    x_q;
	logic signed [31:0]    prev_q;
	logic signed [31:0]    old_q;
	logic signed [SW-1:0]  short_sum_q;
	logic signed [SW-1:0]  long_sum_q;
	logic [AW-1:0]         wp_q;
	logic [CW-1:0]         wc_q;
	logic [CW-1:0]         target_q;
	logic [15:0]           frac_q;
	logic signed [31:0]    sa_q;
	logic signed [31:0]    la_q;
	logic signed [49:0]    prod_q;
	logic signed [50:0]    acc_q;
	logic                  out_valid_q;
	logic signed [31:0]    out_q;

	// divider registers
	logic [31:0]           rem_q;
	logic [DW-1:0]         dvd_q;
	logic [31:0]           dvs_q;
	logic [NW-1:0]         cnt_q;
	logic                  neg_q;

	logic [32:0]           trial;
	logic [33:0]           diff;
	logic                  ge;
	logic [31:0]           rem_next;
	logic [DW-1:0]         dvd_next;
	logic                  div_done;
	logic signed [31:0]    quot_sat;

	logic [DW-1:0]         q_sel;
	logic [AW-1:0]         rd_addr;
	logic signed [31:0]    rd_data;
	logic                  hist_we;
	logic                  accept;
	logic                  cfg_wr;
	logic                  out_load;
	logic [CW-1:0]         wc_m1;
	logic signed [SW-1:0]  x_ext;
	logic signed [SW-1:0]  prev_ext;
	logic signed [SW-1:0]  old_ext;
	logic signed [SW-1:0]  two_ext;
	logic signed [SW-1:0]  short_mag;
	logic signed [SW-1:0]  long_mag;
	logic signed [34:0]    acc_sh;
	logic signed [17:0]    w_short;
	logic signed [17:0]    w_long;

	// address of the entry b samples back from the write pointer
	function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
	                                            input logic [CW-1:0] b);
		logic [AW+1:0] t;
		t = {2'b00, wp} + (AW+2)'(HISTORY_DEPTH) - {1'b0, b};
		if (t >= (AW+2)'(HISTORY_DEPTH)) begin
			t = t - (AW+2)'(HISTORY_DEPTH);
		end
		return t[AW-1:0];
	endfunction

	// signed, saturated 32-bit value from quotient magnitude and sign
	function automatic logic signed [31:0] sat_quot(input logic [DW-1:0] mag,
	                                                input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			if (mag > DW'(33'h0_8000_0000)) begin
				r = 32'sh8000_0000;
			end else begin
				r = -$signed(mag[31:0]);
			end
		end else begin
			if (mag > DW'(32'h7FFF_FFFF)) begin
				r = 32'sh7FFF_FFFF;
			end else begin
				r = $signed(mag[31:0]);
			end
		end
		return r;
	endfunction

	// handshakes
	assign sample_stall  = (state_q != ST_IDLE);
	assign accept        = sample_valid && !sample_stall;
	assign average_valid = out_valid_q;
	assign average       = out_q;
	assign out_load      = (state_q == ST_FIN) && (!out_valid_q || !average_stall);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SAMPLE_PERIOD);
	assign prdata = (paddr[2] == REG_SAMPLE_PERIOD) ? sample_period_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= 32'h0;
		end else if (cfg_wr) begin
			sample_period_q <= pwdata;
		end
	end

	// shared divider step: one quotient bit a cycle
	assign trial    = {rem_q, dvd_q[DW-1]};
	assign diff     = {1'b0, trial} - {2'b00, dvs_q};
	assign ge       = !diff[33];
	assign rem_next = ge ? diff[31:0] : trial[31:0];
	assign dvd_next = {dvd_q[DW-2:0], ge};
	assign div_done = (cnt_q == NW'(DW - 1));
	assign quot_sat = sat_quot(dvd_next, neg_q);

	// window quotient, saturated
	always_comb begin
		if (sample_period_q == 32'h0 || dvd_next > MAX_Q) begin
			q_sel = MAX_Q;
		end else begin
			q_sel = dvd_next;
		end
	end

	// history reads
	assign wc_m1 = wc_q - CW'(1);
	assign rd_addr = (state_q == ST_RD2) ? back_addr(wp_q, wc_m1) : back_addr(wp_q, wc_q);
	assign hist_we = (state_q == ST_UPD);

	vpma_ram #(
		.WIDTH(32),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (hist_we),
		.waddr(wp_q),
		.wdata(x_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// sum update terms
	assign x_ext     = SW'(x_q);
	assign prev_ext  = SW'(prev_q);
	assign old_ext   = SW'(old_q);
	assign two_ext   = old_ext + SW'(rd_data);
	assign short_mag = short_sum_q[SW-1] ? -short_sum_q : short_sum_q;
	assign long_mag  = long_sum_q[SW-1] ? -long_sum_q : long_sum_q;
	assign acc_sh    = 35'(acc_q >>> 16);

	// blend weights: 1 - frac for the short average, frac for the long one
	assign w_short = $signed({1'b0, 17'(17'h1_0000 - {1'b0, frac_q})});
	assign w_long  = $signed({2'b00, frac_q});

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			prev_q      <= 32'sh0;
			short_sum_q <= '0;
			long_sum_q  <= '0;
			wp_q        <= '0;
			wc_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !average_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (period > 32'sh0) ? ST_DIVQ : ST_FIN;
						cnt_q   <= '0;
					end
				end
				ST_DIVQ: begin
					cnt_q <= cnt_q + NW'(1);
					if (div_done) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (target_q > wc_q) begin
						short_sum_q <= short_sum_q + prev_ext;
						long_sum_q  <= long_sum_q + x_ext;
						wc_q        <= wc_q + CW'(1);
					end else if (target_q < wc_q) begin
						short_sum_q <= short_sum_q + prev_ext - two_ext;
						long_sum_q  <= long_sum_q + x_ext - two_ext;
						wc_q        <= wc_m1;
					end else begin
						short_sum_q <= short_sum_q + prev_ext - old_ext;
						long_sum_q  <= long_sum_q + x_ext - old_ext;
					end
					wp_q    <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
					prev_q  <= x_q;
					state_q <= ST_SETS;
				end
				ST_SETS: begin
					cnt_q   <= '0;
					state_q <= (wc_q > CW'(1)) ? ST_DIVS : ST_SETL;
				end
				ST_DIVS: begin
					cnt_q <= cnt_q + NW'(1);
					if (div_done) begin
						state_q <= ST_SETL;
					end
				end
				ST_SETL: begin
					cnt_q   <= '0;
					state_q <= ST_DIVL;
				end
				ST_DIVL: begin
					cnt_q <= cnt_q + NW'(1);
					if (div_done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= sample;
				rem_q <= 32'h0;
				dvd_q <= DW'({period, 16'h0000});
				dvs_q <= sample_period_q;
				neg_q <= 1'b0;
				acc_q <= '0;
			end
			ST_DIVQ: begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				if (div_done) begin
					target_q <= CW'(q_sel[AW+15:16]) + CW'(1);
					frac_q   <= q_sel[15:0];
				end
			end
			ST_RD2: begin
				old_q <= rd_data;
			end
			ST_SETS: begin
				sa_q  <= 32'sh0;
				rem_q <= 32'h0;
				dvd_q <= DW'(short_mag);
				dvs_q <= 32'(wc_m1);
				neg_q <= short_sum_q[SW-1];
			end
			ST_DIVS: begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				if (div_done) begin
					sa_q <= quot_sat;
				end
			end
			ST_SETL: begin
				rem_q <= 32'h0;
				dvd_q <= DW'(long_mag);
				dvs_q <= 32'(wc_q);
				neg_q <= long_sum_q[SW-1];
			end
			ST_DIVL: begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				if (div_done) begin
					la_q <= quot_sat;
				end
			end
			ST_MUL1: begin
				prod_q <= 50'(sa_q) * 50'(w_short);
			end
			ST_MUL2: begin
				acc_q <= 51'(prod_q) + 51'(la_q) * 51'(w_long) + 51'sd32768;
			end
			ST_FIN: begin
				if (out_load) begin
					if (acc_sh > 35'sh0_7FFF_FFFF) begin
						out_q <= 32'sh7FFF_FFFF;
					end else if (acc_sh < -35'sh0_8000_0000) begin
						out_q <= 32'sh8000_0000;
					end else begin
						out_q <= acc_sh[31:0];
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

/* src/vpma_checker.sv */
// Port-level checks for the moving average, bound to the top level.
`default_nettype none
module vpma_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        sample_valid,
	input wire logic        sample_stall,
	input wire logic        average_valid,
	input wire logic        average_stall,
	input wire logic [31:0] average
);
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		average_valid && average_stall |=> average_valid && $stable(average))
		else $error("stalled result changed");

	// one item at a time: the block stalls right after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("input taken while busy");

	// a result only appears out of a busy phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(average_valid) |-> $past(sample_stall))
		else $error("result without an item in work");

	// no result while in reset
	assert property (@(posedge clk) !arst_n |-> !average_valid)
		else $error("result valid during reset");
endmodule

bind variable_period_moving_average vpma_checker u_vpma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.average_valid(average_valid),
	.average_stall(average_stall),
	.average      (average)
);
`default_nettype wire
